[hdl/tnq_pkg.sv]
`timescale 1ns / 1ps
// types, codes and speed tables shared by the trackball click qualifier
package tnq_pkg;

  // event kinds of a result
  localparam logic [2:0] KIND_NONE  = 3'd0;
  localparam logic [2:0] KIND_KBD   = 3'd1;
  localparam logic [2:0] KIND_UP    = 3'd2;
  localparam logic [2:0] KIND_DOWN  = 3'd3;
  localparam logic [2:0] KIND_LEFT  = 3'd4;
  localparam logic [2:0] KIND_RIGHT = 3'd5;
  localparam logic [2:0] KIND_ENTER = 3'd6;

  localparam logic [7:0] CODE_ENTER = 8'd10;

  // configuration register indexes
  localparam logic [1:0] CFG_NAV_SPEED     = 2'd0;
  localparam logic [1:0] CFG_LONG_PRESS    = 2'd1;
  localparam logic [1:0] CFG_RELEASE_DEB   = 2'd2;
  localparam logic [1:0] CFG_TOUCH_POLL    = 2'd3;

  localparam int CfgDataW = 16;

  // register reset values
  localparam logic [2:0]  NAV_SPEED_RST   = 3'd3;
  localparam logic [15:0] LONG_PRESS_RST  = 16'd800;
  localparam logic [9:0]  RELEASE_DEB_RST = 10'd50;
  localparam logic [9:0]  TOUCH_POLL_RST  = 10'd20;

  localparam logic [2:0] SPEED_MIN = 3'd1;
  localparam logic [2:0] SPEED_MAX = 3'd5;

  typedef struct packed {
    logic [2:0]  nav_speed;
    logic [15:0] press_hold_ms;
    logic [9:0]  release_debounce_ms;
    logic [9:0]  touch_interval_ms;
  } tnq_cfg_t;

  typedef struct packed {
    logic [31:0]       now_ms;
    logic              kbd_event;
    logic [7:0]        kbd_code;
    logic              ball_moved;
    logic signed [7:0] delta_x;
    logic signed [7:0] delta_y;
    logic              click_low;
    logic              screen_on;
    logic              touch_present;
    logic              touched;
  } tnq_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] event_code;
    logic       activity;
    logic       strong_activity;
    logic       long_press;
  } tnq_result_t;

  // timing and click state (accumulators travel separately, their width is a parameter)
  typedef struct packed {
    logic [31:0] last_nav_time;
    logic        click_pending;
    logic        long_fired;
    logic [31:0] click_start_time;
    logic [31:0] last_low_time;
    logic        press_began_screen_on;
    logic [31:0] last_touch_time;
  } tnq_state_t;

  // accumulator magnitude needed to fire, per speed level
  function automatic logic [2:0] nav_threshold(input logic [2:0] speed);
    logic [2:0] th;
    unique case (speed)
      3'd1:    th = 3'd5;
      3'd2:    th = 3'd4;
      3'd3:    th = 3'd3;
      3'd4:    th = 3'd2;
      3'd5:    th = 3'd1;
      default: th = 3'd5;
    endcase
    return th;
  endfunction

  // minimum milliseconds between navigation events, per speed level
  function automatic logic [8:0] nav_interval(input logic [2:0] speed);
    logic [8:0] iv;
    unique case (speed)
      3'd1:    iv = 9'd260;
      3'd2:    iv = 9'd220;
      3'd3:    iv = 9'd180;
      3'd4:    iv = 9'd140;
      3'd5:    iv = 9'd100;
      default: iv = 9'd260;
    endcase
    return iv;
  endfunction

endpackage

[hdl/trackball_nav_click_qualifier.sv]
`timescale 1ns / 1ps
// Trackball navigation and click qualifier, top level.
// Each accepted poll yields exactly one result transaction, registered in the output
// register, or in the skid entry while the output is held; a new poll is taken every
// clock while in_stall is low. The whole poll is worked in one pass of logic between
// the input port and the output register; an output register plus one skid entry let
// a poll be accepted while the previous result still waits, and in_stall rises only
// when both are full. Configuration is written through cfg_we/cfg_index/cfg_data; a
// speed outside 1 to 5 is stored clamped to that range.
module trackball_nav_click_qualifier #(
  parameter int ACCUM_LIMIT = 20
) (
  input  logic                          clk,
  input  logic                          rst,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tnq_pkg::CfgDataW-1:0]  cfg_data,
  // poll input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   now_ms,
  input  logic                          kbd_event,
  input  logic [7:0]                    kbd_code,
  input  logic                          ball_moved,
  input  logic signed [7:0]             delta_x,
  input  logic signed [7:0]             delta_y,
  input  logic                          click_low,
  input  logic                          screen_on,
  input  logic                          touch_present,
  input  logic                          touched,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    event_kind,
  output logic [7:0]                    event_code,
  output logic                          activity,
  output logic                          strong_activity,
  output logic                          long_press
);
  import tnq_pkg::*;

  localparam int AccW = $clog2(ACCUM_LIMIT + 1) + 1;
  localparam logic signed [AccW-1:0] AccMax = AccW'(ACCUM_LIMIT);

  tnq_cfg_t    cfg;
  tnq_item_t   item;
  tnq_state_t  st, st_next;
  tnq_result_t res_new, out_res, skid_res;
  logic signed [AccW-1:0] accum_x, accum_y, accum_x_next, accum_y_next;
  logic skid_valid;
  logic in_accept, out_take;
  logic [2:0] speed_wr;

  assign item = '{now_ms: now_ms, kbd_event: kbd_event, kbd_code: kbd_code,
                  ball_moved: ball_moved, delta_x: delta_x, delta_y: delta_y,
                  click_low: click_low, screen_on: screen_on,
                  touch_present: touch_present, touched: touched};

  assign in_stall  = skid_valid;
  assign in_accept = in_valid && !in_stall;
  assign out_take  = out_valid && !out_stall;

  // speed write clamped into the table range
  always_comb begin
    priority if (cfg_data[2:0] < SPEED_MIN) speed_wr = SPEED_MIN;
    else if (cfg_data[2:0] > SPEED_MAX)     speed_wr = SPEED_MAX;
    else                                    speed_wr = cfg_data[2:0];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.nav_speed           <= NAV_SPEED_RST;
      cfg.press_hold_ms       <= LONG_PRESS_RST;
      cfg.release_debounce_ms <= RELEASE_DEB_RST;
      cfg.touch_interval_ms   <= TOUCH_POLL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NAV_SPEED:   cfg.nav_speed           <= speed_wr;
        CFG_LONG_PRESS:  cfg.press_hold_ms       <= cfg_data[15:0];
        CFG_RELEASE_DEB: cfg.release_debounce_ms <= cfg_data[9:0];
        CFG_TOUCH_POLL:  cfg.touch_interval_ms   <= cfg_data[9:0];
        default:         cfg.nav_speed           <= cfg.nav_speed;
      endcase
    end
  end

  tnq_poll_step #(
    .ACCUM_LIMIT (ACCUM_LIMIT),
    .AccW        (AccW)
  ) u_step (
    .cfg        (cfg),
    .item       (item),
    .st         (st),
    .acc_x      (accum_x),
    .acc_y      (accum_y),
    .st_next    (st_next),
    .acc_x_next (accum_x_next),
    .acc_y_next (accum_y_next),
    .res        (res_new)
  );

  // poll state advances on every accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st      <= '0;
      accum_x <= '0;
      accum_y <= '0;
    end else if (in_accept) begin
      st      <= st_next;
      accum_x <= accum_x_next;
      accum_y <= accum_y_next;
    end
  end

  // output register with one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_accept;
      end
    end else if (in_accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_take) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_accept) begin
        out_res <= res_new;
      end
    end else if (in_accept) begin
      skid_res <= res_new;
    end
  end

  assign event_kind      = out_res.event_kind;
  assign event_code      = out_res.event_code;
  assign activity        = out_res.activity;
  assign strong_activity = out_res.strong_activity;
  assign long_press      = out_res.long_press;

  // skid entry is only used behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry full while output register empty");

  // stored speed always selects a table entry
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    cfg.nav_speed >= SPEED_MIN && cfg.nav_speed <= SPEED_MAX)
    else $error("nav speed outside table range");

  // accumulators stay within the clamp limit
  a_accum_bound: assert property (@(posedge clk) disable iff (rst)
    accum_x <= AccMax && accum_x >= -AccMax && accum_y <= AccMax && accum_y >= -AccMax)
    else $error("accumulator beyond clamp limit");

  // a long press suppresses any other event of the same poll
  a_long_press_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && long_press |-> event_kind == KIND_NONE && event_code == 8'd0)
    else $error("event reported together with long press");

  // enter always carries the enter code
  a_enter_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && event_kind == KIND_ENTER |-> event_code == CODE_ENTER)
    else $error("enter event with wrong code");

endmodule

[hdl/tnq_poll_step.sv]
`timescale 1ns / 1ps
// combinational next state and result for one poll
module tnq_poll_step #(
  parameter int ACCUM_LIMIT = 20,
  parameter int AccW = $clog2(ACCUM_LIMIT + 1) + 1
) (
  input  tnq_pkg::tnq_cfg_t      cfg,
  input  tnq_pkg::tnq_item_t     item,
  input  tnq_pkg::tnq_state_t    st,
  input  logic signed [AccW-1:0] acc_x,
  input  logic signed [AccW-1:0] acc_y,
  output tnq_pkg::tnq_state_t    st_next,
  output logic signed [AccW-1:0] acc_x_next,
  output logic signed [AccW-1:0] acc_y_next,
  output tnq_pkg::tnq_result_t   res
);
  import tnq_pkg::*;

  localparam int SumW = ((AccW > 8) ? AccW : 8) + 1;
  localparam logic signed [SumW-1:0] LimS   = SumW'(ACCUM_LIMIT);
  localparam logic signed [AccW-1:0] AccMax = AccW'(ACCUM_LIMIT);

  logic signed [SumW-1:0] sum_x, sum_y;
  logic signed [AccW-1:0] cx, cy;
  logic [AccW-1:0] ax, ay;
  logic [7:0] ax_w, ay_w, th_w;
  logic ydom, nav_time_ok, nav_fire;
  logic [2:0] nav_kind;
  logic has;

  // saturating accumulation, formed wide then clamped
  assign sum_x = SumW'(acc_x) + SumW'(item.delta_x);
  assign sum_y = SumW'(acc_y) + SumW'(item.delta_y);

  always_comb begin
    priority if (sum_x > LimS) cx = AccMax;
    else if (sum_x < -LimS)    cx = -AccMax;
    else                       cx = AccW'(sum_x);
  end

  always_comb begin
    priority if (sum_y > LimS) cy = AccMax;
    else if (sum_y < -LimS)    cy = -AccMax;
    else                       cy = AccW'(sum_y);
  end

  // dominant axis and threshold test
  assign ax   = cx[AccW-1] ? AccW'(-cx) : AccW'(cx);
  assign ay   = cy[AccW-1] ? AccW'(-cy) : AccW'(cy);
  assign ax_w = 8'(ax);
  assign ay_w = 8'(ay);
  assign th_w = 8'(nav_threshold(cfg.nav_speed));
  assign ydom = ay_w >= ax_w;
  assign nav_time_ok = (item.now_ms - st.last_nav_time) >= 32'(nav_interval(cfg.nav_speed));

  always_comb begin
    nav_fire = 1'b0;
    nav_kind = KIND_NONE;
    if (ydom && ay_w >= th_w) begin
      nav_fire = 1'b1;
      nav_kind = cy[AccW-1] ? KIND_UP : KIND_DOWN;
    end else if (!ydom && ax_w >= th_w) begin
      nav_fire = 1'b1;
      nav_kind = cx[AccW-1] ? KIND_LEFT : KIND_RIGHT;
    end
  end

  // keyboard, navigation, click and touch in poll order
  always_comb begin
    st_next    = st;
    acc_x_next = acc_x;
    acc_y_next = acc_y;
    res        = '0;
    has        = 1'b0;

    if (item.kbd_event) begin
      res.event_kind      = KIND_KBD;
      res.event_code      = item.kbd_code;
      res.activity        = 1'b1;
      res.strong_activity = 1'b1;
      has                 = 1'b1;
    end
    if (item.ball_moved) begin
      res.activity = 1'b1;
    end

    // navigation only when no keyboard event and the screen is on
    if (!item.kbd_event && item.screen_on) begin
      acc_x_next = cx;
      acc_y_next = cy;
      if (nav_time_ok && nav_fire) begin
        res.event_kind      = nav_kind;
        res.event_code      = '0;
        res.activity        = 1'b1;
        res.strong_activity = 1'b1;
        has                 = 1'b1;
        st_next.last_nav_time = item.now_ms;
        acc_x_next = '0;
        acc_y_next = '0;
      end
    end

    // click press, long press and debounced release
    if (item.click_low) begin
      st_next.last_low_time = item.now_ms;
      if (!st.click_pending) begin
        st_next.click_pending         = 1'b1;
        st_next.long_fired            = 1'b0;
        st_next.click_start_time      = item.now_ms;
        st_next.press_began_screen_on = item.screen_on;
        res.activity                  = 1'b1;
        res.strong_activity           = 1'b1;
      end else if (!st.long_fired &&
                   (item.now_ms - st.click_start_time) >= 32'(cfg.press_hold_ms)) begin
        res.long_press         = st.press_began_screen_on;
        st_next.long_fired     = 1'b1;
        has                    = 1'b0;
        res.event_kind         = KIND_NONE;
        res.event_code         = '0;
        res.activity           = 1'b1;
        res.strong_activity    = 1'b1;
      end
    end else if (st.click_pending) begin
      if ((item.now_ms - st.last_low_time) >= 32'(cfg.release_debounce_ms)) begin
        st_next.click_pending = 1'b0;
        st_next.long_fired    = 1'b0;
        if (!st.long_fired && !has && st.press_began_screen_on) begin
          res.event_kind        = KIND_ENTER;
          res.event_code        = CODE_ENTER;
          res.activity          = 1'b1;
          res.strong_activity   = 1'b1;
          st_next.last_nav_time = item.now_ms;
          acc_x_next = '0;
          acc_y_next = '0;
        end
      end
    end

    // touch sampled at most once per interval
    if (item.touch_present && item.screen_on) begin
      if ((item.now_ms - st.last_touch_time) >= 32'(cfg.touch_interval_ms)) begin
        st_next.last_touch_time = item.now_ms;
        if (item.touched) begin
          res.activity        = 1'b1;
          res.strong_activity = 1'b1;
        end
      end
    end
  end

endmodule
